@@ hdl/dq_pkg.sv @@
// Shared types and codes for the double-ended queue.
`default_nettype none
package dq_pkg;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
   localparam logic [2:0] OP_PEEK_BACK  = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam int unsigned WORD_W = 32;

   localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;
   localparam logic signed [WORD_W-1:0] ZERO_WORD  = 32'sd0;

   typedef struct packed {
      logic [2:0]               func;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] data;
      logic [1:0]               status;
      logic                     empty_now;
   } rsp_type;

endpackage
`default_nettype wire

@@ hdl/dq_ram.sv @@
// Slot memory: one write port, one read port, registered read data.
`default_nettype none
module dq_ram
   import dq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [AW-1:0]            wr_addr,
   input  wire logic signed [WORD_W-1:0] wr_data,
   input  wire logic                     rd_en,
   input  wire logic [AW-1:0]            rd_addr,
   output logic signed [WORD_W-1:0]      rd_data
);

   logic signed [WORD_W-1:0] mem_ff [DEPTH];
   logic signed [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ hdl/double_ended_queue_top.sv @@
// Double-ended queue of signed words in a circular slot memory.
// Latency: a result is registered and valid in the cycle after its word is accepted.
// Throughput: one word per cycle unless stalled; at most one memory read or write per word.
// Reset clears head index, entry count and the result valid flag.
// The slot memory is not cleared; only slots written by a push are ever read.
`default_nettype none
module double_ended_queue_top
   import dq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  wire req_type req_word,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output rsp_type   rsp_word
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
   localparam logic [SW-1:0] DEPTH_SW  = SW'(DEPTH);

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     sel_mem_ff, sel_mem_in;
   logic signed [WORD_W-1:0] fix_data_ff, fix_data_in;
   logic [1:0]               status_ff, status_in;
   logic                     empty_ff, empty_in;

   logic                     accept;
   logic                     queue_empty, queue_full;
   logic [AW-1:0]            head_dn, head_up, back_slot, tail_slot;
   logic [SW-1:0]            back_sum, tail_sum;
   logic                     wr_en, rd_en;
   logic [AW-1:0]            wr_addr, rd_addr;
   logic signed [WORD_W-1:0] rd_data;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign queue_empty = (count_ff == '0);
   assign queue_full  = (count_ff == FULL_CNT);

   // modular steps without a divider: inputs stay below twice DEPTH
   assign head_dn   = (head_ff == '0) ? LAST_SLOT : head_ff - 1'b1;
   assign head_up   = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
   assign back_sum  = SW'(head_ff) + SW'(count_ff);
   assign back_slot = (back_sum >= DEPTH_SW) ? AW'(back_sum - DEPTH_SW) : AW'(back_sum);
   assign tail_sum  = back_sum - 1'b1;
   assign tail_slot = (tail_sum >= DEPTH_SW) ? AW'(tail_sum - DEPTH_SW) : AW'(tail_sum);

   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      wr_en       = 1'b0;
      wr_addr     = back_slot;
      rd_en       = 1'b0;
      rd_addr     = head_ff;
      sel_mem_in  = 1'b0;
      fix_data_in = ZERO_WORD;
      status_in   = ST_OK;
      case (req_word.func)
         OP_PUSH_FRONT: begin
            if (queue_full) begin
               status_in = ST_FULL;
            end else begin
               head_in  = head_dn;
               count_in = count_ff + 1'b1;
               wr_en    = accept;
               wr_addr  = head_dn;
            end
         end
         OP_PUSH_BACK: begin
            if (queue_full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
               wr_en    = accept;
               wr_addr  = back_slot;
            end
         end
         OP_POP_FRONT, OP_PEEK_FRONT: begin
            if (queue_empty) begin
               status_in   = ST_EMPTY;
               fix_data_in = EMPTY_WORD;
            end else begin
               rd_en      = accept;
               rd_addr    = head_ff;
               sel_mem_in = 1'b1;
               if (req_word.func == OP_POP_FRONT) begin
                  head_in  = head_up;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         OP_POP_BACK, OP_PEEK_BACK: begin
            if (queue_empty) begin
               status_in   = ST_EMPTY;
               fix_data_in = EMPTY_WORD;
            end else begin
               rd_en      = accept;
               rd_addr    = tail_slot;
               sel_mem_in = 1'b1;
               if (req_word.func == OP_POP_BACK) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      empty_in = (count_in == '0);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sel_mem_ff  <= sel_mem_in;
         fix_data_ff <= fix_data_in;
         status_ff   <= status_in;
         empty_ff    <= empty_in;
      end
   end

   dq_ram #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_word.value),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // read data register only loads on an accepted read, so it holds under stall
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_word.data      = sel_mem_ff ? rd_data : fix_data_ff;
   assign rsp_word.status    = status_ff;
   assign rsp_word.empty_now = empty_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count above depth");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= LAST_SLOT)
      else $error("head index out of range");

   a_full_push: assert property (@(posedge clock) disable iff (reset)
      accept && queue_full &&
      (req_word.func == OP_PUSH_FRONT || req_word.func == OP_PUSH_BACK)
      |=> rsp_word.status == ST_FULL && count_ff == FULL_CNT)
      else $error("push on full queue not rejected");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      accept && !queue_empty &&
      (req_word.func == OP_POP_FRONT || req_word.func == OP_POP_BACK)
      |=> count_ff == CW'($past(count_ff) - 1'b1) && rsp_word.status == ST_OK)
      else $error("pop did not remove one entry");
`endif

endmodule
`default_nettype wire
